### design/srdc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor readout display controller package
// Shared types, constants, the segment encoder and the control store.
// ----------------------------------------------------------------------------
package srdc_pkg;

	localparam int MUL_W  = 16;
	localparam int DIV_W  = 32;
	localparam int CFG_W  = 25;
	localparam int CIDX_W = 3;
	localparam int STEP_W = 4;

	localparam logic [6:0]  TEMP_MAX   = 7'd99;
	localparam logic [15:0] PERIOD_MAX = 16'hFFFF;

	typedef enum logic [CIDX_W-1:0] {
		CFG_ALARM_THRESHOLD = 3'd0,
		CFG_TEMP_SCALE      = 3'd1,
		CFG_MIN_FREQUENCY   = 3'd2,
		CFG_MAX_FREQUENCY   = 3'd3,
		CFG_DAC_CLOCK       = 3'd4,
		CFG_WAVE_SAMPLES    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		COND_NEXT     = 2'd0,
		COND_DISPATCH = 2'd1,
		COND_DIV_WAIT = 2'd2,
		COND_EMIT     = 2'd3
	} cond_t;

	typedef enum logic [1:0] {
		MUL_NONE   = 2'd0,
		MUL_TEMP   = 2'd1,
		MUL_FREQ   = 2'd2,
		MUL_PERIOD = 2'd3
	} mul_sel_t;

	typedef enum logic [1:0] {
		DIV_NONE  = 2'd0,
		DIV_FULL  = 2'd1,
		DIV_CLOCK = 2'd2
	} div_sel_t;

	typedef enum logic [1:0] {
		WR_NONE   = 2'd0,
		WR_TEMP   = 2'd1,
		WR_FREQ   = 2'd2,
		WR_PERIOD = 2'd3
	} wr_sel_t;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		cond_t    cond;
		mul_sel_t mul_sel;
		div_sel_t div_sel;
		wr_sel_t  wr_sel;
		step_t    jump;
	} uword_t;

	typedef struct packed {
		uword_t word;
		logic   go;
	} seq_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic in_op;
		logic div_busy;
		logic out_free;
	} seq_status_t;

	localparam step_t STEP_DISPATCH = 4'd0;
	localparam step_t STEP_EMIT     = 4'd10;
	localparam step_t STEP_LAST     = 4'd10;

	function automatic uword_t ucode(input step_t step);
		uword_t w;
		w = '{cond: COND_NEXT, mul_sel: MUL_NONE, div_sel: DIV_NONE,
			wr_sel: WR_NONE, jump: STEP_DISPATCH};
		case (step)
			4'd0: begin
				w.cond = COND_DISPATCH;
				w.jump = STEP_EMIT;
			end
			4'd1: w.mul_sel = MUL_TEMP;
			4'd2: w.div_sel = DIV_FULL;
			4'd3: begin
				w.cond   = COND_DIV_WAIT;
				w.wr_sel = WR_TEMP;
			end
			4'd4: w.mul_sel = MUL_FREQ;
			4'd5: w.div_sel = DIV_FULL;
			4'd6: begin
				w.cond   = COND_DIV_WAIT;
				w.wr_sel = WR_FREQ;
			end
			4'd7: w.mul_sel = MUL_PERIOD;
			4'd8: w.div_sel = DIV_CLOCK;
			4'd9: begin
				w.cond   = COND_DIV_WAIT;
				w.wr_sel = WR_PERIOD;
			end
			4'd10: begin
				w.cond = COND_EMIT;
				w.jump = STEP_DISPATCH;
			end
			default: w.jump = STEP_DISPATCH;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] seg_code(input logic [3:0] d);
		logic [6:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	// Valid for values up to 99: tens = (t * 205) >> 11.
	function automatic logic [3:0] tens_of(input logic [6:0] t);
		logic [14:0] p;
		p = 15'(t) * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] units_of(input logic [6:0] t);
		logic [6:0] r;
		r = t - 7'(tens_of(t)) * 7'd10;
		return r[3:0];
	endfunction

endpackage

### design/srdc_if.sv
// ----------------------------------------------------------------------------
// Sensor readout display controller channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface srdc_in_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic [SAMPLE_BITS-1:0] adc_sample;

	modport source (output valid, output op, output adc_sample, input ready);
	modport sink (input valid, input op, input adc_sample, output ready);
endinterface

interface srdc_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  segments;
	logic [1:0]  digit_enable;
	logic        alarm;
	logic [6:0]  temperature;
	logic [15:0] tone_frequency;
	logic [15:0] dac_period;

	modport source (output valid, output segments, output digit_enable, output alarm,
		output temperature, output tone_frequency, output dac_period, input ready);
	modport sink (input valid, input segments, input digit_enable, input alarm,
		input temperature, input tone_frequency, input dac_period, output ready);
endinterface

### design/srdc_divider.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srdc_divider #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             busy,
	output logic [WIDTH-1:0] quotient
);

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dsr_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] trial;
	logic             ge;

	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
	assign ge      = !trial[WIDTH+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(WIDTH);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			busy_q <= (cnt_q != CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WIDTH-2:0], ge};
			rem_q <= ge ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

### design/srdc_sequencer.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module srdc_sequencer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  srdc_pkg::seq_status_t   status,
	output srdc_pkg::seq_ctrl_t     ctrl
);

	srdc_pkg::step_t  step_q;
	srdc_pkg::step_t  step_nxt;
	srdc_pkg::uword_t word;
	logic             go;

	assign word = srdc_pkg::ucode(step_q);

	always_comb begin
		go       = 1'b0;
		step_nxt = step_q;
		case (word.cond)
			srdc_pkg::COND_NEXT: begin
				go       = 1'b1;
				step_nxt = step_q + srdc_pkg::step_t'(1);
			end
			srdc_pkg::COND_DISPATCH: begin
				go       = status.in_valid;
				step_nxt = status.in_op ? word.jump : step_q + srdc_pkg::step_t'(1);
			end
			srdc_pkg::COND_DIV_WAIT: begin
				go       = !status.div_busy;
				step_nxt = step_q + srdc_pkg::step_t'(1);
			end
			srdc_pkg::COND_EMIT: begin
				go       = status.out_free;
				step_nxt = word.jump;
			end
			default: begin
				go       = 1'b1;
				step_nxt = srdc_pkg::STEP_DISPATCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= srdc_pkg::STEP_DISPATCH;
		end else if (go) begin
			step_q <= step_nxt;
		end
	end

	assign ctrl.word = word;
	assign ctrl.go   = go;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= srdc_pkg::STEP_LAST)
		else $error("step counter left the program");

endmodule

### design/sensor_readout_display_controller_core.sv
// ----------------------------------------------------------------------------
// Sensor readout display controller
// Converts a sample to temperature, digit patterns, alarm, tone and DAC
// period; a scan tick multiplexes the two display digits.
// ----------------------------------------------------------------------------
// A scan tick goes from the dispatch step straight to the emit step, which loads the
// output register once it is free. A sample runs two full-scale divisions by
// folding, one pass through the iterative divider for the DAC period, and the
// multiply and control steps of the microprogram.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears control state and restores register and state defaults.
module sensor_readout_display_controller_core #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [srdc_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [srdc_pkg::CFG_W-1:0]    cfg_data,
	srdc_in_if.sink                       in_ch,
	srdc_out_if.source                    out_ch
);

	localparam logic [srdc_pkg::DIV_W-1:0] FULL_SCALE =
		srdc_pkg::DIV_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	logic [6:0]  alarm_threshold_q;
	logic [9:0]  temp_scale_q;
	logic [15:0] min_frequency_q;
	logic [15:0] max_frequency_q;
	logic [24:0] dac_clock_q;
	logic [7:0]  wave_samples_q;

	logic [6:0]  temp_q;
	logic [6:0]  tens_q;
	logic [6:0]  units_q;
	logic        show_units_q;
	logic [6:0]  drv_seg_q;
	logic [1:0]  drv_digit_q;
	logic        alarm_q;
	logic [15:0] freq_q;
	logic [15:0] period_q;

	logic [SAMPLE_BITS-1:0]         sample_q;
	logic [2*srdc_pkg::MUL_W-1:0]   prod_q;

	logic        out_valid_q;
	logic [6:0]  o_seg_q;
	logic [1:0]  o_digit_q;
	logic        o_alarm_q;
	logic [6:0]  o_temp_q;
	logic [15:0] o_freq_q;
	logic [15:0] o_period_q;

	srdc_pkg::seq_status_t status;
	srdc_pkg::seq_ctrl_t   ctrl;

	logic                         dispatch_go;
	logic                         emit_go;
	logic                         in_acc;
	logic                         div_start;
	logic                         div_busy;
	logic [srdc_pkg::DIV_W-1:0]   div_dividend;
	logic [srdc_pkg::DIV_W-1:0]   div_divisor;
	logic [srdc_pkg::DIV_W-1:0]   quotient;
	logic                         fs_start;
	logic                         fs_busy_q;
	logic [srdc_pkg::DIV_W-1:0]   fs_quo_q;
	logic [srdc_pkg::DIV_W-1:0]   fs_rem_q;
	logic [srdc_pkg::DIV_W-1:0]   fs_hi;
	logic [srdc_pkg::DIV_W-1:0]   fs_lo;
	logic [srdc_pkg::MUL_W-1:0]   mul_a;
	logic [srdc_pkg::MUL_W-1:0]   mul_b;
	logic                         freq_up;
	logic [15:0]                  freq_span;
	logic [6:0]                   temp_new;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_threshold_q <= 7'd55;
			temp_scale_q      <= 10'd330;
			min_frequency_q   <= 16'd100;
			max_frequency_q   <= 16'd1000;
			dac_clock_q       <= 25'd25000000;
			wave_samples_q    <= 8'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				srdc_pkg::CFG_ALARM_THRESHOLD: alarm_threshold_q <= cfg_data[6:0];
				srdc_pkg::CFG_TEMP_SCALE:      temp_scale_q      <= cfg_data[9:0];
				srdc_pkg::CFG_MIN_FREQUENCY:   min_frequency_q   <= cfg_data[15:0];
				srdc_pkg::CFG_MAX_FREQUENCY:   max_frequency_q   <= cfg_data[15:0];
				srdc_pkg::CFG_DAC_CLOCK:       dac_clock_q       <= cfg_data[24:0];
				srdc_pkg::CFG_WAVE_SAMPLES:    wave_samples_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign status.in_valid = in_ch.valid;
	assign status.in_op    = in_ch.op;
	assign status.div_busy = div_busy || fs_busy_q;
	assign status.out_free = !out_valid_q || out_ch.ready;

	srdc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_ch.ready = (ctrl.word.cond == srdc_pkg::COND_DISPATCH);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign dispatch_go = ctrl.go && (ctrl.word.cond == srdc_pkg::COND_DISPATCH);
	assign emit_go     = ctrl.go && (ctrl.word.cond == srdc_pkg::COND_EMIT);

	assign freq_up   = (max_frequency_q >= min_frequency_q);
	assign freq_span = freq_up ? (max_frequency_q - min_frequency_q)
		: (min_frequency_q - max_frequency_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.word.mul_sel)
			srdc_pkg::MUL_TEMP: begin
				mul_a = srdc_pkg::MUL_W'(sample_q);
				mul_b = srdc_pkg::MUL_W'(temp_scale_q);
			end
			srdc_pkg::MUL_FREQ: begin
				mul_a = srdc_pkg::MUL_W'(sample_q);
				mul_b = freq_span;
			end
			srdc_pkg::MUL_PERIOD: begin
				mul_a = freq_q;
				mul_b = srdc_pkg::MUL_W'(wave_samples_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dispatch_go) begin
			sample_q <= in_ch.adc_sample;
		end
		if (ctrl.word.mul_sel != srdc_pkg::MUL_NONE) begin
			prod_q <= {{srdc_pkg::MUL_W{1'b0}}, mul_a} * {{srdc_pkg::MUL_W{1'b0}}, mul_b};
		end
	end

	// Division by the full-scale value 2^N - 1: the bits above N are folded
	// back onto the low part until the remainder fits in N bits; a remainder of 2^N - 1 then adds one to the quotient.
	assign fs_start = ctrl.go && (ctrl.word.div_sel == srdc_pkg::DIV_FULL);
	assign fs_hi    = fs_rem_q >> SAMPLE_BITS;
	assign fs_lo    = fs_rem_q & FULL_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_busy_q <= 1'b0;
		end else if (fs_start) begin
			fs_busy_q <= 1'b1;
		end else if (fs_busy_q && (fs_hi == '0)) begin
			fs_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fs_start) begin
			fs_quo_q <= '0;
			fs_rem_q <= prod_q;
		end else if (fs_busy_q) begin
			if (fs_hi != '0) begin
				fs_quo_q <= fs_quo_q + fs_hi;
				fs_rem_q <= fs_hi + fs_lo;
			end else if (fs_rem_q == FULL_SCALE) begin
				fs_quo_q <= fs_quo_q + srdc_pkg::DIV_W'(1);
				fs_rem_q <= '0;
			end
		end
	end

	assign div_dividend = srdc_pkg::DIV_W'(dac_clock_q);
	assign div_divisor  = prod_q;
	assign div_start    = ctrl.go && (ctrl.word.div_sel == srdc_pkg::DIV_CLOCK);

	srdc_divider #(
		.WIDTH (srdc_pkg::DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign temp_new = (fs_quo_q > srdc_pkg::DIV_W'(srdc_pkg::TEMP_MAX))
		? srdc_pkg::TEMP_MAX : fs_quo_q[6:0];

	// Readout state and display scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q       <= '0;
			tens_q       <= '0;
			units_q      <= '0;
			show_units_q <= 1'b0;
			drv_seg_q    <= '0;
			drv_digit_q  <= '0;
			alarm_q      <= 1'b0;
			freq_q       <= 16'd550;
			period_q     <= 16'd757;
		end else begin
			if (dispatch_go && in_ch.op) begin
				drv_seg_q    <= show_units_q ? units_q : tens_q;
				drv_digit_q  <= show_units_q ? 2'b10 : 2'b01;
				show_units_q <= !show_units_q;
			end
			if (ctrl.go) begin
				case (ctrl.word.wr_sel)
					srdc_pkg::WR_TEMP: begin
						temp_q  <= temp_new;
						tens_q  <= srdc_pkg::seg_code(srdc_pkg::tens_of(temp_new));
						units_q <= srdc_pkg::seg_code(srdc_pkg::units_of(temp_new));
						alarm_q <= (temp_new > alarm_threshold_q);
					end
					srdc_pkg::WR_FREQ: begin
						freq_q <= freq_up ? (min_frequency_q + fs_quo_q[15:0])
							: (min_frequency_q - fs_quo_q[15:0]);
					end
					srdc_pkg::WR_PERIOD: begin
						period_q <= (quotient > srdc_pkg::DIV_W'(srdc_pkg::PERIOD_MAX))
							? srdc_pkg::PERIOD_MAX : quotient[15:0];
					end
					default: ;
				endcase
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			o_seg_q    <= drv_seg_q;
			o_digit_q  <= drv_digit_q;
			o_alarm_q  <= alarm_q;
			o_temp_q   <= temp_q;
			o_freq_q   <= freq_q;
			o_period_q <= period_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.segments       = o_seg_q;
	assign out_ch.digit_enable   = o_digit_q;
	assign out_ch.alarm          = o_alarm_q;
	assign out_ch.temperature    = o_temp_q;
	assign out_ch.tone_frequency = o_freq_q;
	assign out_ch.dac_period     = o_period_q;

	a_temp_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		temp_q <= srdc_pkg::TEMP_MAX)
		else $error("temperature above clamp");

	a_scan_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.op) |=> $onehot(drv_digit_q))
		else $error("scan tick did not enable exactly one digit");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ch.ready)
		else $error("second transaction accepted while one is in work");

endmodule

### dv/tb_sensor_readout_display_controller_core.sv
// ----------------------------------------------------------------------------
// Sensor readout display controller testbench
// Sends converter samples and scan ticks through the input channel with
// random gaps and output stalls, predicts each readout from a behavioral
// model of temperature, display, alarm, tone and DAC period, and compares
// every returned transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_sensor_readout_display_controller_core;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 12;
	localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;
	localparam logic [6:0] DIGIT_SEG [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
		7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

	typedef struct packed {
		logic [6:0]  segments;
		logic [1:0]  digit_enable;
		logic        alarm;
		logic [6:0]  temperature;
		logic [15:0] tone_frequency;
		logic [15:0] dac_period;
	} readout_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [srdc_pkg::CIDX_W-1:0] cfg_index;
	logic [srdc_pkg::CFG_W-1:0]  cfg_data;

	srdc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch();
	srdc_out_if out_ch();

	sensor_readout_display_controller_core #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Register copies and display state of the behavioral model.
	int unsigned threshold_reg, scale_reg, fmin_reg, fmax_reg, dac_clock_reg, wave_reg;
	logic [6:0]  temp_now, tens_seg, units_seg, seg_driven;
	logic        units_next, alarm_now;
	logic [1:0]  digit_driven;
	logic [15:0] freq_now, period_now;

	readout_t pending_readouts[$];
	int       mismatch_count;
	bit       send_idle_on, recv_idle_on;
	int       hold_off_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#8ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic void reset_model();
		threshold_reg = 55;
		scale_reg     = 330;
		fmin_reg      = 100;
		fmax_reg      = 1000;
		dac_clock_reg = 25000000;
		wave_reg      = 60;
		temp_now      = '0;
		tens_seg      = '0;
		units_seg     = '0;
		units_next    = 1'b0;
		seg_driven    = '0;
		digit_driven  = '0;
		alarm_now     = 1'b0;
		freq_now      = 16'd550;
		period_now    = 16'd757;
	endfunction

	function automatic readout_t predict_readout(input logic op, input logic [11:0] smp);
		longint unsigned s64, t;
		int unsigned f, d, p;
		readout_t r;
		if (op == OP_SAMPLE) begin
			s64 = smp;
			t = s64 * scale_reg / FULL_SCALE;
			if (t > 99)
				t = 99;
			temp_now  = 7'(t);
			tens_seg  = DIGIT_SEG[(t / 10) % 10];
			units_seg = DIGIT_SEG[t % 10];
			alarm_now = (t > threshold_reg);
			if (fmax_reg >= fmin_reg)
				f = fmin_reg + 32'(s64 * (fmax_reg - fmin_reg) / FULL_SCALE);
			else
				f = fmin_reg - 32'(s64 * (fmin_reg - fmax_reg) / FULL_SCALE);
			freq_now = f[15:0];
			d = 32'(freq_now) * wave_reg;
			if (d == 0) begin
				period_now = srdc_pkg::PERIOD_MAX;
			end else begin
				p = dac_clock_reg / d;
				period_now = (p > 65535) ? srdc_pkg::PERIOD_MAX : p[15:0];
			end
		end else begin
			if (!units_next) begin
				seg_driven   = tens_seg;
				digit_driven = 2'b01;
			end else begin
				seg_driven   = units_seg;
				digit_driven = 2'b10;
			end
			units_next = ~units_next;
		end
		r.segments       = seg_driven;
		r.digit_enable   = digit_driven;
		r.alarm          = alarm_now;
		r.temperature    = temp_now;
		r.tone_frequency = freq_now;
		r.dac_period     = period_now;
		return r;
	endfunction

	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(99, 0);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi,
		input int unsigned typ_hi);
		int r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		if (r < 6)
			return $urandom_range(typ_hi, lo);
		return $urandom_range(hi, lo);
	endfunction

	task automatic write_reg(input srdc_pkg::cfg_idx_t idx, input int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= srdc_pkg::CFG_W'(val);
		@(posedge clk);
		case (idx)
			srdc_pkg::CFG_ALARM_THRESHOLD: threshold_reg = val & 32'h7F;
			srdc_pkg::CFG_TEMP_SCALE:      scale_reg     = val & 32'h3FF;
			srdc_pkg::CFG_MIN_FREQUENCY:   fmin_reg      = val & 32'hFFFF;
			srdc_pkg::CFG_MAX_FREQUENCY:   fmax_reg      = val & 32'hFFFF;
			srdc_pkg::CFG_DAC_CLOCK:       dac_clock_reg = val & 32'h1FF_FFFF;
			srdc_pkg::CFG_WAVE_SAMPLES:    wave_reg      = val & 32'hFF;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic op, input logic [11:0] smp);
		int gap;
		gap = pick_gap(send_idle_on);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.op         <= op;
		in_ch.adc_sample <= smp;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_readouts.push_back(predict_readout(op, smp));
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_readout();
		readout_t got, want;
		got.segments       = out_ch.segments;
		got.digit_enable   = out_ch.digit_enable;
		got.alarm          = out_ch.alarm;
		got.temperature    = out_ch.temperature;
		got.tone_frequency = out_ch.tone_frequency;
		got.dac_period     = out_ch.dac_period;
		if (pending_readouts.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: unexpected transaction seg=%h dig=%b alarm=%b temp=%0d freq=%0d per=%0d",
					$realtime, got.segments, got.digit_enable, got.alarm, got.temperature,
					got.tone_frequency, got.dac_period);
			return;
		end
		want = pending_readouts.pop_front();
		if (got.segments !== want.segments || got.digit_enable !== want.digit_enable ||
			got.alarm !== want.alarm || got.temperature !== want.temperature ||
			got.tone_frequency !== want.tone_frequency ||
			got.dac_period !== want.dac_period) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: expected seg=%h dig=%b alarm=%b temp=%0d freq=%0d per=%0d",
					$realtime, want.segments, want.digit_enable, want.alarm,
					want.temperature, want.tone_frequency, want.dac_period);
				$display("%0t: actual   seg=%h dig=%b alarm=%b temp=%0d freq=%0d per=%0d",
					$realtime, got.segments, got.digit_enable, got.alarm,
					got.temperature, got.tone_frequency, got.dac_period);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_readout();
	end

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		int n;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_cycles > 0) begin
				n = hold_off_cycles;
				hold_off_cycles = 0;
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = pick_gap(recv_idle_on);
				if (n > 0) begin
					out_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end else begin
					out_ch.ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	task automatic test_reset_state();
		send_item(OP_TICK, '0);
		send_item(OP_TICK, '0);
		wait_idle();
	endtask

	task automatic test_sample_extremes();
		send_item(OP_SAMPLE, 12'd0);
		send_item(OP_TICK, '0);
		send_item(OP_TICK, '0);
		send_item(OP_SAMPLE, 12'd4095);
		send_item(OP_TICK, '0);
		send_item(OP_SAMPLE, 12'd1);
		send_item(OP_TICK, '0);
		send_item(OP_SAMPLE, 12'd4094);
		send_item(OP_SAMPLE, 12'd2048);
		send_item(OP_TICK, '0);
		wait_idle();
	endtask

	task automatic test_special_cases();
		write_reg(srdc_pkg::CFG_ALARM_THRESHOLD, 127);
		write_reg(srdc_pkg::CFG_TEMP_SCALE, 1023);
		end_writes();
		send_item(OP_SAMPLE, 12'd4095);
		send_item(OP_TICK, '0);
		wait_idle();
		write_reg(srdc_pkg::CFG_ALARM_THRESHOLD, 0);
		write_reg(srdc_pkg::CFG_TEMP_SCALE, 330);
		write_reg(srdc_pkg::CFG_MIN_FREQUENCY, 65535);
		write_reg(srdc_pkg::CFG_MAX_FREQUENCY, 1);
		end_writes();
		send_item(OP_SAMPLE, 12'd13);
		send_item(OP_SAMPLE, 12'd4095);
		send_item(OP_SAMPLE, 12'd2000);
		send_item(OP_TICK, '0);
		wait_idle();
		write_reg(srdc_pkg::CFG_MIN_FREQUENCY, 0);
		write_reg(srdc_pkg::CFG_MAX_FREQUENCY, 0);
		write_reg(srdc_pkg::CFG_DAC_CLOCK, 33554431);
		write_reg(srdc_pkg::CFG_WAVE_SAMPLES, 1);
		end_writes();
		send_item(OP_SAMPLE, 12'd0);
		wait_idle();
		write_reg(srdc_pkg::CFG_MIN_FREQUENCY, 1);
		end_writes();
		send_item(OP_SAMPLE, 12'd7);
		wait_idle();
		write_reg(srdc_pkg::CFG_MIN_FREQUENCY, 65535);
		write_reg(srdc_pkg::CFG_MAX_FREQUENCY, 65535);
		write_reg(srdc_pkg::CFG_DAC_CLOCK, 1);
		write_reg(srdc_pkg::CFG_WAVE_SAMPLES, 255);
		end_writes();
		send_item(OP_SAMPLE, 12'd3000);
		send_item(OP_TICK, '0);
		wait_idle();
	endtask

	task automatic test_random_phases();
		int r;
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(srdc_pkg::CFG_ALARM_THRESHOLD, pick_value(0, 127, 99));
			write_reg(srdc_pkg::CFG_TEMP_SCALE, pick_value(0, 1023, 400));
			write_reg(srdc_pkg::CFG_MIN_FREQUENCY, pick_value(1, 65535, 2000));
			write_reg(srdc_pkg::CFG_MAX_FREQUENCY, pick_value(1, 65535, 5000));
			write_reg(srdc_pkg::CFG_DAC_CLOCK, pick_value(1, 33554431, 50000000 / 2));
			write_reg(srdc_pkg::CFG_WAVE_SAMPLES, pick_value(1, 255, 100));
			end_writes();
			send_idle_on = (phase % 4) < 2;
			recv_idle_on = (phase % 2) == 0;
			for (int k = 0; k < 100; k++) begin
				r = $urandom_range(9, 0);
				if (r == 0)
					send_item(OP_SAMPLE, 12'd0);
				else if (r == 1)
					send_item(OP_SAMPLE, 12'd4095);
				else
					send_item(logic'($urandom_range(1, 0)), 12'($urandom));
			end
			wait_idle();
		end
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		send_idle_on = 1'b0;
		hold_off_cycles = 400;
		for (int k = 0; k < 12; k++)
			send_item(logic'(k % 3 != 0), 12'($urandom));
		send_idle_on = 1'b1;
		wait_idle();
	endtask

	initial begin
		mismatch_count   = 0;
		hold_off_cycles  = 0;
		send_idle_on     = 1'b1;
		recv_idle_on     = 1'b1;
		reset_model();
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.op         <= OP_SAMPLE;
		in_ch.adc_sample <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_sample_extremes();
		test_special_cases();
		test_random_phases();
		test_output_backpressure();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_readouts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
